/* hdl/lie_pkg.sv */
// Shared constants and codes for the Lagrange interpolation evaluator.
// No dependencies; used by lagrange_interpolation_eval.
`default_nettype none
package lie_pkg;

    localparam int MAX_POINTS = 16;
    localparam int FRAC_BITS  = 16;

    // store address and fill count widths
    localparam int PT_AW = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    // ratio divider: |num| is 33 bits, shifted up by the fraction bits
    localparam int DIV_W  = 33 + FRAC_BITS;
    localparam int DCNT_W = $clog2(DIV_W + 1);

    // full product of a 63-bit term magnitude and the ratio quotient
    localparam int PW = 63 + DIV_W;

    localparam logic signed [63:0] WIDE_LIMIT = 64'sh3FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_EVAL  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DUP   = 3'd1,
        ST_EMPTY = 3'd2,
        ST_OVF   = 3'd3,
        ST_FULL  = 3'd4
    } status_t;

endpackage
`default_nettype wire

/* hdl/lagrange_interpolation_eval.sv */
// Lagrange interpolation evaluator, signed Q16.16, one shared divider and multiplier.
// Depends on lie_pkg.
`default_nettype none
// Usage:
//  Request channel (req_valid / req_stall): action, coord_x, coord_y.
//    clear  - empties the point store, answers value 0 / status ok.
//    load   - stores (coord_x, coord_y); when the store is full the point
//             is dropped and status reports store full.
//    eval   - evaluates the interpolating polynomial at coord_x.
//    action code 3 is consumed and gives no response.
//  Response channel (rsp_valid / rsp_stall): value, status.
//  Requests are taken only when the sequencer is idle; one request is in
//  flight at a time, and a finished response waits in the output register
//  while the next request is taken.
//  Clear and load go straight to the done state after acceptance. An
//  evaluation over n points first checks every pair for duplicate x, then
//  runs one ratio divide and multiply for each pair (i, j) with j != i.
//  The ratio divider is bit-serial, one quotient bit a cycle; the multiply
//  takes four 32x32 partial products.
//  Reset empties the store and clears the response valid flag. When the
//  receiver stalls, the response holds and a finished next result waits
//  in the done state until the register frees up.
module lagrange_interpolation_eval (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire logic [1:0]         action,
    input  wire logic signed [31:0] coord_x,
    input  wire logic signed [31:0] coord_y,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output logic signed [31:0]      value,
    output logic [2:0]              status
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_DUP_RD   = 12'b0000_0000_0010,
        S_DUP_CMP  = 12'b0000_0000_0100,
        S_TRM_RD   = 12'b0000_0000_1000,
        S_TRM_INIT = 12'b0000_0001_0000,
        S_J_RD     = 12'b0000_0010_0000,
        S_J_SET    = 12'b0000_0100_0000,
        S_DIV      = 12'b0000_1000_0000,
        S_MUL      = 12'b0001_0000_0000,
        S_MSAT     = 12'b0010_0000_0000,
        S_ACC      = 12'b0100_0000_0000,
        S_DONE     = 12'b1000_0000_0000
    } state_t;

    localparam int CW = lie_pkg::CNT_W;
    localparam int AW = lie_pkg::PT_AW;
    localparam int FB = lie_pkg::FRAC_BITS;
    localparam int DW = lie_pkg::DIV_W;
    localparam int PW = lie_pkg::PW;

    state_t state_reg, state_next;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic signed [31:0] q_reg, q_next;

    // point store, registered reads
    logic [31:0] xs_mem [lie_pkg::MAX_POINTS];
    logic [31:0] ys_mem [lie_pkg::MAX_POINTS];
    logic [31:0] xi_reg, xj_reg, yi_reg;
    logic        wr_en;

    logic signed [63:0] t_reg, t_next;
    logic signed [63:0] acc_reg, acc_next;
    logic               ovf_reg, ovf_next;
    logic               rneg_reg, rneg_next;

    logic [DW-1:0]          dvd_reg, dvd_next;
    logic [32:0]            dvs_reg, dvs_next;
    logic [32:0]            rem_reg, rem_next;
    logic [lie_pkg::DCNT_W-1:0] dcnt_reg, dcnt_next;

    logic [2:0]    mstep_reg, mstep_next;
    logic [63:0]   prod_reg, prod_next;
    logic [PW-1:0] pacc_reg, pacc_next;

    logic signed [31:0] res_val_reg, res_val_next;
    logic [2:0]         res_st_reg, res_st_next;

    logic               rsp_valid_reg;
    logic signed [31:0] value_reg;
    logic [2:0]         status_reg;

    logic accept;
    logic out_free;

    // datapath helpers
    logic signed [32:0] num, den;
    logic [32:0]        num_mag, den_mag;
    logic [33:0]        rsh;
    logic               ge;
    logic [63:0]        tmag;
    logic [31:0]        mul_a, mul_b;
    logic [PW-1:0]      pp_ext;
    logic               mov;
    logic [61:0]        mres;
    logic               tneg;
    logic signed [64:0] sum65;
    logic               j_more;

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign wr_en     = accept && (action == lie_pkg::ACT_LOAD)
                       && (cnt_reg < CW'(lie_pkg::MAX_POINTS));

    assign rsp_valid = rsp_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    assign num     = {q_reg[31], q_reg} - {xj_reg[31], xj_reg};
    assign den     = {xi_reg[31], xi_reg} - {xj_reg[31], xj_reg};
    assign num_mag = num[32] ? (~num + 33'd1) : num;
    assign den_mag = den[32] ? (~den + 33'd1) : den;

    // one restoring divide step
    assign rsh = {rem_reg, dvd_reg[DW-1]};
    assign ge  = (rsh >= {1'b0, dvs_reg});

    assign tmag = t_reg[63] ? (~t_reg + 64'd1) : t_reg;

    always_comb
    begin
        case (mstep_reg)
            3'd0:    begin mul_a = tmag[31:0];          mul_b = dvd_reg[31:0]; end
            3'd1:    begin mul_a = tmag[31:0];          mul_b = 32'(dvd_reg[DW-1:32]); end
            3'd2:    begin mul_a = {1'b0, tmag[62:32]}; mul_b = dvd_reg[31:0]; end
            3'd3:    begin mul_a = {1'b0, tmag[62:32]}; mul_b = 32'(dvd_reg[DW-1:32]); end
            default: begin mul_a = 32'd0;               mul_b = 32'd0; end
        endcase
    end

    // product registered at step k is added at step k+1
    always_comb
    begin
        case (mstep_reg)
            3'd1:    pp_ext = PW'(prod_reg);
            3'd2:    pp_ext = PW'(prod_reg) << 32;
            3'd3:    pp_ext = PW'(prod_reg) << 32;
            3'd4:    pp_ext = PW'(prod_reg) << 64;
            default: pp_ext = '0;
        endcase
    end

    assign mov   = |pacc_reg[PW-1:62+FB];
    assign mres  = mov ? 62'h3FFF_FFFF_FFFF_FFFF : pacc_reg[61+FB:FB];
    assign tneg  = t_reg[63] ^ rneg_reg;
    assign sum65 = {acc_reg[63], acc_reg} + {t_reg[63], t_reg};
    assign j_more = ({1'b0, j_reg} + (CW+1)'(1)) < {1'b0, n_reg};

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        q_next       = q_reg;
        t_next       = t_reg;
        acc_next     = acc_reg;
        ovf_next     = ovf_reg;
        rneg_next    = rneg_reg;
        dvd_next     = dvd_reg;
        dvs_next     = dvs_reg;
        rem_next     = rem_reg;
        dcnt_next    = dcnt_reg;
        mstep_next   = mstep_reg;
        prod_next    = prod_reg;
        pacc_next    = pacc_reg;
        res_val_next = res_val_reg;
        res_st_next  = res_st_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_val_next = '0;
                    res_st_next  = lie_pkg::ST_OK;
                    case (action)
                        lie_pkg::ACT_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_DONE;
                        end
                        lie_pkg::ACT_LOAD:
                        begin
                            if (wr_en)
                                cnt_next = cnt_reg + CW'(1);
                            else
                                res_st_next = lie_pkg::ST_FULL;
                            state_next = S_DONE;
                        end
                        lie_pkg::ACT_EVAL:
                        begin
                            q_next   = coord_x;
                            n_next   = cnt_reg;
                            acc_next = '0;
                            ovf_next = 1'b0;
                            i_next   = '0;
                            if (cnt_reg == '0)
                            begin
                                res_st_next = lie_pkg::ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else if (cnt_reg == CW'(1))
                            begin
                                j_next     = '0;
                                state_next = S_TRM_RD;
                            end
                            else
                            begin
                                j_next     = CW'(1);
                                state_next = S_DUP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_DUP_RD:
                state_next = S_DUP_CMP;

            S_DUP_CMP:
            begin
                if (xi_reg == xj_reg)
                begin
                    res_st_next = lie_pkg::ST_DUP;
                    state_next  = S_DONE;
                end
                else if (j_more)
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_DUP_RD;
                end
                else if (({1'b0, i_reg} + (CW+1)'(2)) < {1'b0, n_reg})
                begin
                    i_next     = i_reg + CW'(1);
                    j_next     = i_reg + CW'(2);
                    state_next = S_DUP_RD;
                end
                else
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = S_TRM_RD;
                end
            end

            S_TRM_RD:
                state_next = S_TRM_INIT;

            S_TRM_INIT:
            begin
                t_next     = {{32{yi_reg[31]}}, yi_reg};
                state_next = S_J_SET;
            end

            S_J_RD:
                state_next = S_J_SET;

            S_J_SET:
            begin
                if (j_reg == i_reg)
                begin
                    if (j_more)
                    begin
                        j_next     = j_reg + CW'(1);
                        state_next = S_J_RD;
                    end
                    else
                        state_next = S_ACC;
                end
                else
                begin
                    dvd_next   = {num_mag, {FB{1'b0}}};
                    dvs_next   = den_mag;
                    rem_next   = '0;
                    rneg_next  = num[32] ^ den[32];
                    dcnt_next  = lie_pkg::DCNT_W'(DW);
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                rem_next  = ge ? 33'(rsh - {1'b0, dvs_reg}) : rsh[32:0];
                dvd_next  = {dvd_reg[DW-2:0], ge};
                dcnt_next = dcnt_reg - lie_pkg::DCNT_W'(1);
                if (dcnt_reg == lie_pkg::DCNT_W'(1))
                begin
                    mstep_next = '0;
                    pacc_next  = '0;
                    state_next = S_MUL;
                end
            end

            S_MUL:
            begin
                prod_next  = mul_a * mul_b;
                pacc_next  = pacc_reg + pp_ext;
                mstep_next = mstep_reg + 3'd1;
                if (mstep_reg == 3'd4)
                    state_next = S_MSAT;
            end

            S_MSAT:
            begin
                t_next   = tneg ? -$signed({2'b00, mres}) : $signed({2'b00, mres});
                ovf_next = ovf_reg | mov;
                if (j_more)
                begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_J_RD;
                end
                else
                    state_next = S_ACC;
            end

            S_ACC:
            begin
                if (sum65 > 65'(lie_pkg::WIDE_LIMIT))
                begin
                    acc_next = lie_pkg::WIDE_LIMIT;
                    ovf_next = 1'b1;
                end
                else if (sum65 < -65'(lie_pkg::WIDE_LIMIT))
                begin
                    acc_next = -lie_pkg::WIDE_LIMIT;
                    ovf_next = 1'b1;
                end
                else
                    acc_next = sum65[63:0];

                if (({1'b0, i_reg} + (CW+1)'(1)) < {1'b0, n_reg})
                begin
                    i_next     = i_reg + CW'(1);
                    j_next     = '0;
                    state_next = S_TRM_RD;
                end
                else
                begin
                    // sum is final; saturate it to 32 bits into the result register
                    state_next = S_DONE;
                    if (acc_next > 64'sd2147483647)
                    begin
                        res_val_next = 32'sh7FFF_FFFF;
                        res_st_next  = lie_pkg::ST_OVF;
                    end
                    else if (acc_next < -64'sd2147483648)
                    begin
                        res_val_next = 32'sh8000_0000;
                        res_st_next  = lie_pkg::ST_OVF;
                    end
                    else
                    begin
                        res_val_next = acc_next[31:0];
                        res_st_next  = ovf_next ? lie_pkg::ST_OVF : lie_pkg::ST_OK;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // point store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            xs_mem[cnt_reg[AW-1:0]] <= coord_x;
            ys_mem[cnt_reg[AW-1:0]] <= coord_y;
        end
        xi_reg <= xs_mem[i_reg[AW-1:0]];
        xj_reg <= xs_mem[j_reg[AW-1:0]];
        yi_reg <= ys_mem[i_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (state_reg == S_DONE && out_free)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        q_reg       <= q_next;
        t_reg       <= t_next;
        acc_reg     <= acc_next;
        ovf_reg     <= ovf_next;
        rneg_reg    <= rneg_next;
        dvd_reg     <= dvd_next;
        dvs_reg     <= dvs_next;
        rem_reg     <= rem_next;
        dcnt_reg    <= dcnt_next;
        mstep_reg   <= mstep_next;
        prod_reg    <= prod_next;
        pacc_reg    <= pacc_next;
        res_val_reg <= res_val_next;
        res_st_reg  <= res_st_next;
        if (state_reg == S_DONE && out_free)
        begin
            value_reg  <= res_val_reg;
            status_reg <= res_st_reg;
        end
    end

    // store fill never passes capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(lie_pkg::MAX_POINTS))
        else $error("point count above capacity");

    // a new response only ever comes out of the done state
    a_rsp_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("response raised outside done state");

    // duplicate check must keep zero divisors out of the divider
    a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (dvs_reg != 33'd0))
        else $error("zero divisor in ratio divider");

endmodule
`default_nettype wire

/* sim/lagrange_interpolation_eval_tb.sv */
// Self-checking bench for the Lagrange interpolation evaluator: directed table, then random runs
// of clear/load/eval requests, checked against an in-bench fixed-point predictor.
// Depends on lie_pkg and lagrange_interpolation_eval.
`default_nettype none
module lagrange_interpolation_eval_tb;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    logic [1:0]         action;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic signed [31:0] value;
    logic [2:0]         status;

    lagrange_interpolation_eval uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall),
        .action(action), .coord_x(coord_x), .coord_y(coord_y),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .value(value), .status(status)
    );

    // one stored answer: interpolated value and status code
    typedef struct packed {
        logic signed [31:0] val;
        lie_pkg::status_t   st;
    } answer_t;

    // predictor copy of the point store
    logic signed [31:0] pred_xs [lie_pkg::MAX_POINTS];
    logic signed [31:0] pred_ys [lie_pkg::MAX_POINTS];
    int                 pred_count;

    answer_t pending_answers [$];
    int      errors = 0;
    int      row_errors;
    int      cycle_count = 0;
    int      send_idle_pct;
    int      recv_idle_pct;

    localparam int CYCLE_LIMIT = 8000000;

    // magnitude product shifted down by the fraction bits, saturated to the wide range
    function automatic logic signed [63:0] scale_term(input logic signed [63:0] a,
                                                      input logic signed [63:0] b,
                                                      inout bit ovf);
        logic         neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] prod;
        logic [127:0] sh;
        logic [63:0]  res;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? -a : a;
        ub   = (b < 0) ? -b : b;
        prod = ua * ub;
        sh   = prod >> lie_pkg::FRAC_BITS;
        if (sh > 128'(lie_pkg::WIDE_LIMIT))
        begin
            ovf = 1;
            res = lie_pkg::WIDE_LIMIT;
        end
        else
            res = sh[63:0];
        return neg ? -$signed(res) : $signed(res);
    endfunction

    function automatic answer_t interpolate_at(input logic signed [31:0] q);
        answer_t            ans;
        bit                 ovf;
        logic signed [63:0] acc;
        logic signed [63:0] t;
        logic signed [63:0] num;
        logic signed [63:0] den;
        logic signed [63:0] r;
        logic [63:0]        rm;
        logic [63:0]        un;
        logic [63:0]        ud;
        ans.val = 0;
        ans.st  = lie_pkg::ST_OK;
        ovf = 0;
        acc = 0;
        if (pred_count == 0)
        begin
            ans.st = lie_pkg::ST_EMPTY;
            return ans;
        end
        for (int i = 0; i < pred_count; i++)
            for (int j = i + 1; j < pred_count; j++)
                if (pred_xs[i] == pred_xs[j])
                begin
                    ans.st = lie_pkg::ST_DUP;
                    return ans;
                end
        for (int i = 0; i < pred_count; i++)
        begin
            t = 64'(pred_ys[i]);
            for (int j = 0; j < pred_count; j++)
            begin
                if (j == i)
                    continue;
                num = 64'(q) - 64'(pred_xs[j]);
                den = 64'(pred_xs[i]) - 64'(pred_xs[j]);
                un  = (num < 0) ? -num : num;
                ud  = (den < 0) ? -den : den;
                rm  = (un << lie_pkg::FRAC_BITS) / ud;
                r   = ((num < 0) != (den < 0)) ? -$signed(rm) : $signed(rm);
                t   = scale_term(t, r, ovf);
            end
            acc = acc + t;
            if (acc > lie_pkg::WIDE_LIMIT)
            begin
                acc = lie_pkg::WIDE_LIMIT;
                ovf = 1;
            end
            if (acc < -lie_pkg::WIDE_LIMIT)
            begin
                acc = -lie_pkg::WIDE_LIMIT;
                ovf = 1;
            end
        end
        if (acc > 64'sd2147483647)
        begin
            acc = 64'sd2147483647;
            ovf = 1;
        end
        if (acc < -64'sd2147483648)
        begin
            acc = -64'sd2147483648;
            ovf = 1;
        end
        ans.val = acc[31:0];
        ans.st  = ovf ? lie_pkg::ST_OVF : lie_pkg::ST_OK;
        return ans;
    endfunction

    // advance the predictor by one accepted request; returns 1 when an answer is due
    function automatic bit apply_request(input lie_pkg::action_t act,
                                         input logic signed [31:0] x,
                                         input logic signed [31:0] y, output answer_t ans);
        ans.val = 0;
        ans.st  = lie_pkg::ST_OK;
        case (act)
            lie_pkg::ACT_CLEAR: pred_count = 0;
            lie_pkg::ACT_LOAD:
                if (pred_count >= lie_pkg::MAX_POINTS)
                    ans.st = lie_pkg::ST_FULL;
                else
                begin
                    pred_xs[pred_count] = x;
                    pred_ys[pred_count] = y;
                    pred_count++;
                end
            lie_pkg::ACT_EVAL: ans = interpolate_at(x);
            default: return 0;
        endcase
        return 1;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // cycle watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("lagrange_interpolation_eval_tb: FAIL");
            $finish;
        end
    end

    // response checker and receiver stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: unexpected response value=%0d status=%0d",
                             $time, value, status);
                    errors++;
                end
                else
                begin
                    if (value !== pending_answers[0].val)
                    begin
                        $display("%0t: value expected %0d actual %0d",
                                 $time, pending_answers[0].val, value);
                        errors++;
                    end
                    if (status !== pending_answers[0].st)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, pending_answers[0].st, status);
                        errors++;
                    end
                    void'(pending_answers.pop_front());
                end
            end
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // present one request and hold it until it is taken; valid stays up afterwards
    // so the next request can follow at once
    task automatic send_request(input lie_pkg::action_t act, input logic signed [31:0] x,
                                input logic signed [31:0] y);
        answer_t ans;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 0;
            @(posedge clk);
        end
        req_valid <= 1;
        action    <= act;
        coord_x   <= x;
        coord_y   <= y;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (apply_request(act, x, y, ans))
            pending_answers.push_back(ans);
    endtask

    // directed row with an optional typed-in answer
    typedef struct {
        lie_pkg::action_t   act;
        logic signed [31:0] x;
        logic signed [31:0] y;
        bit                 typed;
        answer_t            ans;
    } vector_t;

    vector_t vectors [$];

    task automatic add_row(input lie_pkg::action_t act, input logic signed [31:0] x,
                           input logic signed [31:0] y, input bit typed,
                           input logic signed [31:0] v, input lie_pkg::status_t st);
        vector_t row;
        row.act = act;
        row.x = x;
        row.y = y;
        row.typed = typed;
        row.ans.val = v;
        row.ans.st = st;
        vectors.push_back(row);
    endtask

    task automatic drain();
        req_valid <= 0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // abscissa: mostly small spaced values, sometimes anywhere
    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(9))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(40)) * 32'sh8000 - 32'sh000A_0000;
        endcase
    endfunction

    task automatic random_phase(input int n_items);
        int sent;
        int npts;
        int n_eval;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                // noise: any action, any data
                send_request(lie_pkg::action_t'($urandom_range(3)), $urandom, $urandom);
                sent++;
            end
            else
            begin
                // well-formed set: clear, a few loads, a few evaluations
                npts = ($urandom_range(19) == 0) ? $urandom_range(lie_pkg::MAX_POINTS + 2)
                                                 : $urandom_range(1, 5);
                n_eval = $urandom_range(1, 3);
                send_request(lie_pkg::ACT_CLEAR, $urandom, $urandom);
                for (int k = 0; k < npts; k++)
                    send_request(lie_pkg::ACT_LOAD, pick_coord(),
                                 $urandom_range(3) == 0 ? $urandom
                                                        : $signed($urandom_range(1 << 20)) - (1 << 19));
                for (int k = 0; k < n_eval; k++)
                    send_request(lie_pkg::ACT_EVAL, pick_coord(), $urandom);
                sent += npts + n_eval + 1;
            end
        end
    endtask

    initial
    begin
        answer_t ans;
        rst_n = 0;
        req_valid = 0;
        action = lie_pkg::ACT_NONE;
        coord_x = 0;
        coord_y = 0;
        row_errors = 0;
        pred_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed table: empty store, single point, line, duplicates, saturation; full store follows
        add_row(lie_pkg::ACT_EVAL,  0, 0, 1, 0, lie_pkg::ST_EMPTY);
        add_row(lie_pkg::ACT_NONE,  0, 0, 0, 0, lie_pkg::ST_OK);
        add_row(lie_pkg::ACT_LOAD,  32'sh0001_0000, 32'sh7FFF_FFFF, 1, 0, lie_pkg::ST_OK);
        add_row(lie_pkg::ACT_EVAL,  32'sh8000_0000, 0, 1, 32'sh7FFF_FFFF, lie_pkg::ST_OK);
        add_row(lie_pkg::ACT_LOAD,  32'sh0002_0000, 32'sh8000_0000, 1, 0, lie_pkg::ST_OK);
        add_row(lie_pkg::ACT_EVAL,  32'sh0001_8000, 0, 0, 0, lie_pkg::ST_OK);
        add_row(lie_pkg::ACT_EVAL,  32'sh7FFF_FFFF, 0, 0, 0, lie_pkg::ST_OK);
        add_row(lie_pkg::ACT_EVAL,  32'sh8000_0000, 0, 0, 0, lie_pkg::ST_OK);
        add_row(lie_pkg::ACT_LOAD,  32'sh0001_0000, 5, 1, 0, lie_pkg::ST_OK);
        add_row(lie_pkg::ACT_EVAL,  0, 0, 1, 0, lie_pkg::ST_DUP);
        add_row(lie_pkg::ACT_CLEAR, 32'shFFFF_FFFF, 32'shFFFF_FFFF, 1, 0, lie_pkg::ST_OK);
        add_row(lie_pkg::ACT_LOAD,  32'sh8000_0000, 32'sh0001_0000, 1, 0, lie_pkg::ST_OK);
        add_row(lie_pkg::ACT_LOAD,  32'sh7FFF_FFFF, 32'sh0001_0000, 1, 0, lie_pkg::ST_OK);
        add_row(lie_pkg::ACT_LOAD,  0, 32'sh7FFF_FFFF, 1, 0, lie_pkg::ST_OK);
        add_row(lie_pkg::ACT_EVAL,  32'sh4000_0000, 0, 0, 0, lie_pkg::ST_OK);
        add_row(lie_pkg::ACT_CLEAR, 0, 0, 1, 0, lie_pkg::ST_OK);
        foreach (vectors[k])
        begin
            send_request(vectors[k].act, vectors[k].x, vectors[k].y);
            if (vectors[k].typed && pending_answers.size() != 0)
            begin
                ans = pending_answers[$];
                if (ans !== vectors[k].ans)
                begin
                    $display("%0t: row %0d expected %0d/%0d predicted %0d/%0d", $time, k,
                             vectors[k].ans.val, vectors[k].ans.st, ans.val, ans.st);
                    row_errors++;
                end
            end
        end
        // fill the store past capacity
        for (int k = 0; k < lie_pkg::MAX_POINTS + 2; k++)
            send_request(lie_pkg::ACT_LOAD, k * 32'sh0000_8000,
                         k * 32'sh0000_4000 - 32'sh0002_0000);
        send_request(lie_pkg::ACT_EVAL, 32'sh0000_C000, 0);

        // hold off until everything is back
        drain();

        send_idle_pct = 9;
        recv_idle_pct = 69;
        random_phase(300);
        drain();
        send_idle_pct = 69;
        recv_idle_pct = 9;
        random_phase(300);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(300);
        drain();
        repeat (100) @(posedge clk);
        if (errors == 0 && row_errors == 0 && pending_answers.size() == 0)
            $display("lagrange_interpolation_eval_tb: PASS");
        else
            $display("lagrange_interpolation_eval_tb: FAIL");
        $finish;
    end
endmodule
`default_nettype wire
